@@ sv/dtbc_pkg.sv @@
package dtbc_pkg;

  localparam int CMD_W = 3;

  localparam logic [2:0] C_ACT = 3'd0;
  localparam logic [2:0] C_RD  = 3'd1;
  localparam logic [2:0] C_WR  = 3'd2;
  localparam logic [2:0] C_RDP = 3'd3;
  localparam logic [2:0] C_WRP = 3'd4;
  localparam logic [2:0] C_PRE = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_UNSUP  = 3'd2;
  localparam logic [2:0] ST_POPPED = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  localparam logic [1:0] K_RD  = 2'd0;
  localparam logic [1:0] K_WR  = 2'd1;
  localparam logic [1:0] K_REF = 2'd2;
  localparam logic [1:0] K_RSV = 2'd3;

  localparam logic [2:0] REG_OPEN   = 3'd0;
  localparam logic [2:0] REG_AUTOP  = 3'd1;
  localparam logic [2:0] REG_STRICT = 3'd2;
  localparam logic [2:0] REG_SENIOR = 3'd3;
  localparam logic [2:0] REG_POSTED = 3'd4;

  // one queued command with its two time stamps
  typedef struct packed {
    logic [2:0]  code;
    logic [13:0] row;
    logic [9:0]  col;
    logic [3:0]  burst;
    logic        posted;
    logic        completes;
    logic [7:0]  tag;
    logic [31:0] enq;
    logic [31:0] st;
  } entry_t;

  typedef struct packed {
    logic        command;
    logic        channel;
    logic [1:0]  rank;
    logic [2:0]  bank;
    logic [13:0] row;
    logic [9:0]  column;
    logic [1:0]  kind;
    logic [3:0]  burst_length;
    logic [31:0] arrive_tick;
    logic [31:0] now;
    logic [7:0]  tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  cmd_code;
    logic [13:0] cmd_row;
    logic [9:0]  cmd_column;
    logic [31:0] origin_tick;
    logic [31:0] enq_tick;
    logic [3:0]  cmd_burst;
    logic        posted;
    logic        completes;
    logic [7:0]  cmd_tag;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_t;

endpackage

@@ sv/dtbc_if.sv @@
interface dtbc_req_if import dtbc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtbc_rsp_if import dtbc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dtbc_cfg_if import dtbc_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/dtbc_store.sv @@
module dtbc_store import dtbc_pkg::*; #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);
  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/dtbc_ctrl.sv @@
module dtbc_ctrl import dtbc_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int RANKS = 4,
  parameter int BANKS = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic clk,
  input  logic rst,
  dtbc_req_if.sink   req,
  dtbc_rsp_if.source rsp,
  dtbc_cfg_if.sink   cfg
);
  localparam int NQ = CHANNELS * RANKS * BANKS;
  localparam int QW = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = QW + PW;
  localparam int MW = OW + PW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_APP  = 4'd2;
  localparam logic [3:0] S_SRD  = 4'd3;
  localparam logic [3:0] S_SCHK = 4'd4;
  localparam logic [3:0] S_SHRD = 4'd5;
  localparam logic [3:0] S_SHWR = 4'd6;
  localparam logic [3:0] S_POPR = 4'd7;
  localparam logic [3:0] S_POPW = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_CLR  = 4'd10;

  logic [3:0] state;
  logic       page_open, autop, strict, posted_cfg;
  logic [15:0] senior;
  req_t       r;
  logic [QW-1:0] q, q_in, clr_idx;
  logic [MW-1:0] qmeta [NQ];
  logic [MW-1:0] meta_rd, meta_wd;
  logic          meta_we;
  logic [QW-1:0] meta_wa;
  logic [OW-1:0] occ_rd;
  logic [PW-1:0] head_rd;
  logic [OW-1:0] occ_q;
  logic [PW-1:0] head_q;
  logic [OW-1:0] off;
  logic [OW-1:0] ins_pos;
  logic [1:0]  app_n, app_i;
  entry_t      app_e [3];
  rsp_t        out;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  entry_t      wdata, rdata;
  logic [31:0] age;
  logic        stop;
  entry_t      base_e, col_e, colp_e, pre_e;

  dtbc_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [PW-1:0] wrap(logic [PW-1:0] h, logic [OW-1:0] o);
    logic [OW:0] s;
    s = {{(OW+1-PW){1'b0}}, h} + {1'b0, o};
    if (s >= (OW+1)'(QUEUE_DEPTH)) s = s - (OW+1)'(QUEUE_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr(logic [QW-1:0] qq, logic [PW-1:0] p);
    return AW'(qq) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  // index modulo a count; address fields are at most 7
  function automatic logic [4:0] fold(logic [4:0] v, int n);
    logic [4:0] x;
    x = v;
    for (int i = 0; i < 8; i++) begin
      if (x >= 5'(n)) x = x - 5'(n);
    end
    return x;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_OUT);
  assign rsp.data = out;
  assign age = r.now - rdata.enq;
  assign stop = strict || (!age[31] && age > {16'd0, senior});
  assign occ_rd = meta_rd[MW-1:PW];
  assign head_rd = meta_rd[PW-1:0];
  assign q_in = QW'((32'(fold(5'(req.data.channel), CHANNELS)) * RANKS
                + 32'(fold(5'(req.data.rank), RANKS))) * BANKS
                + 32'(fold(5'(req.data.bank), BANKS)));

  // occupancy and head per queue, read at the accept edge
  always_ff @(posedge clk) begin
    if (meta_we) begin
      qmeta[meta_wa] <= meta_wd;
    end
    meta_rd <= qmeta[q_in];
  end

  // the activate, column and precharge commands built from the latched request
  always_comb begin
    base_e = '0;
    base_e.code = C_ACT;
    base_e.row = r.row;
    base_e.col = r.column;
    base_e.enq = r.now;
    base_e.st = r.arrive_tick;
    pre_e = base_e;
    pre_e.code = C_PRE;
    col_e = base_e;
    col_e.code = (r.kind == K_WR) ? C_WR : C_RD;
    col_e.burst = r.burst_length;
    col_e.posted = posted_cfg;
    col_e.completes = 1'b1;
    col_e.tag = r.tag;
    colp_e = col_e;
    colp_e.code = (r.kind == K_REF) ? C_PRE : (r.kind == K_WR) ? C_WRP : C_RDP;
  end

  always_comb begin
    we = 1'b0;
    waddr = addr(q, wrap(head_q, occ_q + OW'(app_i)));
    wdata = app_e[app_i];
    raddr = addr(q, wrap(head_q, off));
    unique case (state)
      S_APP: we = 1'b1;
      S_SRD, S_SHRD: raddr = addr(q, wrap(head_q, off - OW'(1)));
      S_SHWR: begin
        we = 1'b1;
        waddr = addr(q, wrap(head_q, off));
        wdata = (off == ins_pos) ? col_e : rdata;
      end
      S_POPR: raddr = addr(q, head_q);
      default: ;
    endcase
  end

  always_comb begin
    meta_we = 1'b0;
    meta_wa = q;
    meta_wd = {occ_q, head_q};
    unique case (state)
      S_CLR: begin
        meta_we = 1'b1;
        meta_wa = clr_idx;
        meta_wd = '0;
      end
      S_APP: if (app_i == app_n - 2'd1) begin
        meta_we = 1'b1;
        meta_wd = {occ_q + OW'(app_n), head_q};
      end
      S_SHWR: if (off == ins_pos) begin
        meta_we = 1'b1;
        meta_wd = {occ_q + OW'(1), head_q};
      end
      S_POPW: begin
        meta_we = 1'b1;
        meta_wd = {occ_q - OW'(1), wrap(head_q, OW'(1))};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      page_open <= 1'b0;
      autop <= 1'b1;
      strict <= 1'b0;
      senior <= 16'd1000;
      posted_cfg <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_OPEN:   page_open <= cfg.data.data[0];
          REG_AUTOP:  autop <= cfg.data.data[0];
          REG_STRICT: strict <= cfg.data.data[0];
          REG_SENIOR: senior <= cfg.data.data;
          REG_POSTED: posted_cfg <= cfg.data.data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + QW'(1);
          if (clr_idx == QW'(NQ - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          r <= req.data;
          q <= q_in;
          out <= '0;
          state <= S_DEC;
        end
        S_DEC: begin
          occ_q <= occ_rd;
          head_q <= head_rd;
          app_i <= '0;
          if (r.command) begin
            if (occ_rd == '0) begin
              out.status <= ST_EMPTY;
              state <= S_OUT;
            end else state <= S_POPR;
          end else if (r.kind == K_RSV
                       || (r.kind == K_REF && (page_open || !autop))) begin
            out.status <= ST_UNSUP;
            state <= S_OUT;
          end else if (!page_open) begin
            if (occ_rd > OW'(QUEUE_DEPTH - 2)
                || (!autop && occ_rd > OW'(QUEUE_DEPTH - 3))) begin
              out.status <= ST_FULL;
              state <= S_OUT;
            end else begin
              app_e[0] <= base_e;
              app_e[1] <= autop ? colp_e : col_e;
              app_e[2] <= pre_e;
              app_n <= autop ? 2'd2 : 2'd3;
              state <= S_APP;
            end
          end else begin
            app_n <= 2'd3;
            app_e[0] <= base_e;
            app_e[1] <= col_e;
            app_e[2] <= pre_e;
            off <= occ_rd;
            state <= S_SRD;
          end
        end
        S_APP: begin
          app_i <= app_i + 2'd1;
          if (app_i == app_n - 2'd1) begin
            out.status <= ST_OK;
            state <= S_OUT;
          end
        end
        // scan from the tail: issue read of entry off-1
        S_SRD: begin
          if (off == '0) begin
            if (occ_q > OW'(QUEUE_DEPTH - 3)) begin
              out.status <= ST_FULL;
              state <= S_OUT;
            end else state <= S_APP;
          end else begin
            off <= off - OW'(1);
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (rdata.code == C_PRE && rdata.row == r.row) begin
            if (occ_q == OW'(QUEUE_DEPTH)) begin
              out.status <= ST_FULL;
              state <= S_OUT;
            end else begin
              ins_pos <= off;
              off <= occ_q;
              state <= (occ_q == off) ? S_SHWR : S_SHRD;
            end
          end else if (stop) begin
            off <= '0;
            state <= S_SRD;
          end else state <= S_SRD;
        end
        // shift entries up one slot, then drop the column command in
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (off == ins_pos) begin
            out.status <= ST_OK;
            state <= S_OUT;
          end else begin
            off <= off - OW'(1);
            state <= (off - OW'(1) == ins_pos) ? S_SHWR : S_SHRD;
          end
        end
        S_POPR: state <= S_POPW;
        S_POPW: begin
          out.status <= ST_POPPED;
          out.cmd_code <= rdata.code;
          out.cmd_row <= rdata.row;
          out.cmd_column <= rdata.col;
          out.origin_tick <= rdata.st;
          out.enq_tick <= rdata.enq;
          out.cmd_burst <= rdata.burst;
          out.posted <= rdata.posted;
          out.completes <= rdata.completes;
          out.cmd_tag <= rdata.tag;
          state <= S_OUT;
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/dram_transaction_to_bank_commands.sv @@
// Per-bank DRAM command queues.
// req: one item per transaction (submit) or pop request; rsp: one item back
// for every req item, carrying status and, for a pop, the head command.
// cfg: register writes (index, data), always ready; write only while idle.
// One item at a time through a small sequencer around a command memory with
// one write port and one registered read port. A reject or an empty pop
// answers after decode; a pop reads the head entry; a close-page submit
// appends 2 or 3 entries; an open-page submit scans back from the tail,
// then appends 3 entries or shifts later entries up to insert the column one.
// The scan and the shift are bounded by the one memory read port.
// rsp holds valid and data until taken; req stays low meanwhile, and the
// next item is taken the cycle after rsp is taken.
// After reset a clearing pass zeroes the occupancy and head pointer of every
// queue with req held low; the register defaults load at once. The command
// memory is not cleared.
module dram_transaction_to_bank_commands import dtbc_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int RANKS = 4,
  parameter int BANKS = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input logic clk,
  input logic rst,
  dtbc_req_if.sink   req,
  dtbc_rsp_if.source rsp,
  dtbc_cfg_if.sink   cfg
);
  dtbc_ctrl #(
    .CHANNELS(CHANNELS), .RANKS(RANKS), .BANKS(BANKS), .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg)
  );
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dtbc_pkg::*;

  localparam int NCH = 2;
  localparam int NRK = 4;
  localparam int NBK = 8;
  localparam int DEPTH = 8;
  localparam int NQ = NCH * NRK * NBK;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dtbc_req_if req ();
  dtbc_rsp_if rsp ();
  dtbc_cfg_if cfg ();

  dram_transaction_to_bank_commands #(
    .CHANNELS(NCH), .RANKS(NRK), .BANKS(NBK), .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // shadow of the bank queues
  entry_t bank_q [NQ][DEPTH];
  int unsigned occ [NQ];
  int unsigned head [NQ];
  logic open_pg, autop, strict_ord, posted_col;
  logic [15:0] senior;

  rsp_t pending_rsp [$];
  int errors = 0;
  int cycles = 0;

  function automatic int unsigned slot(int unsigned q, int unsigned off);
    return (head[q] + off) % DEPTH;
  endfunction

  function automatic void push_cmd(int unsigned q, entry_t e);
    bank_q[q][slot(q, occ[q])] = e;
    occ[q]++;
  endfunction

  function automatic logic [2:0] submit_cmd(int unsigned q, req_t r);
    entry_t act, col, pre;
    int unsigned free_slots;
    int off;
    logic [31:0] age;
    free_slots = DEPTH - occ[q];
    if (r.kind == K_RSV) return ST_UNSUP;
    if (r.kind == K_REF && (open_pg || !autop)) return ST_UNSUP;
    act = '0;
    act.code = C_ACT;
    act.row = r.row;
    act.col = r.column;
    act.enq = r.now;
    act.st = r.arrive_tick;
    pre = act;
    pre.code = C_PRE;
    col = act;
    col.code = (r.kind == K_WR) ? C_WR : C_RD;
    col.burst = r.burst_length;
    col.posted = posted_col;
    col.completes = 1'b1;
    col.tag = r.tag;
    if (!open_pg) begin
      if (free_slots < 2 || (!autop && free_slots < 3)) return ST_FULL;
      push_cmd(q, act);
      if (!autop) begin
        push_cmd(q, col);
        push_cmd(q, pre);
      end else begin
        col.code = (r.kind == K_REF) ? C_PRE : (r.kind == K_WR ? C_WRP : C_RDP);
        push_cmd(q, col);
      end
      return ST_OK;
    end
    off = occ[q];
    while (off > 0) begin
      off--;
      if (bank_q[q][slot(q, off)].code == C_PRE && bank_q[q][slot(q, off)].row == r.row) begin
        if (free_slots < 1) return ST_FULL;
        // shift the tail up by one, then slip the column access in
        for (int i = occ[q]; i > off; i--)
          bank_q[q][slot(q, i)] = bank_q[q][slot(q, i - 1)];
        bank_q[q][slot(q, off)] = col;
        occ[q]++;
        return ST_OK;
      end
      age = r.now - bank_q[q][slot(q, off)].enq;
      if (strict_ord || (!age[31] && age > {16'd0, senior})) break;
    end
    if (free_slots < 3) return ST_FULL;
    push_cmd(q, act);
    push_cmd(q, col);
    push_cmd(q, pre);
    return ST_OK;
  endfunction

  function automatic rsp_t bank_cmd_result(req_t r);
    rsp_t o;
    entry_t e;
    int unsigned q;
    o = '0;
    q = (int'(r.channel) * NRK + int'(r.rank)) * NBK + int'(r.bank);
    if (!r.command) begin
      o.status = submit_cmd(q, r);
    end else if (occ[q] == 0) begin
      o.status = ST_EMPTY;
    end else begin
      e = bank_q[q][slot(q, 0)];
      o.status = ST_POPPED;
      o.cmd_code = e.code;
      o.cmd_row = e.row;
      o.cmd_column = e.col;
      o.origin_tick = e.st;
      o.enq_tick = e.enq;
      o.cmd_burst = e.burst;
      o.posted = e.posted;
      o.completes = e.completes;
      o.cmd_tag = e.tag;
      head[q] = (head[q] + 1) % DEPTH;
      occ[q]--;
    end
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // response side: random stall pattern, compare at rising edge
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      default: rsp.ready <= ($urandom_range(0, 2) == 0);
    endcase
    if (!rst && $urandom_range(0, 60) == 0) stall_mode <= $urandom_range(0, 2);
  end

  always @(posedge clk) begin
    rsp_t w, g;
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      g = rsp.data;
      if (pending_rsp.size() == 0) begin
        report("unexpected item", g.status, 0);
      end else begin
        w = pending_rsp.pop_front();
        if (g.status !== w.status) report("status", g.status, w.status);
        if (g.cmd_code !== w.cmd_code) report("cmd_code", g.cmd_code, w.cmd_code);
        if (g.cmd_row !== w.cmd_row) report("cmd_row", g.cmd_row, w.cmd_row);
        if (g.cmd_column !== w.cmd_column) report("cmd_column", g.cmd_column, w.cmd_column);
        if (g.origin_tick !== w.origin_tick)
          report("origin_tick", g.origin_tick, w.origin_tick);
        if (g.enq_tick !== w.enq_tick) report("enq_tick", g.enq_tick, w.enq_tick);
        if (g.cmd_burst !== w.cmd_burst) report("cmd_burst", g.cmd_burst, w.cmd_burst);
        if (g.posted !== w.posted) report("posted", g.posted, w.posted);
        if (g.completes !== w.completes) report("completes", g.completes, w.completes);
        if (g.cmd_tag !== w.cmd_tag) report("cmd_tag", g.cmd_tag, w.cmd_tag);
      end
    end
  end

  // caller drops cfg.valid after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_OPEN: open_pg = val[0];
      REG_AUTOP: autop = val[0];
      REG_STRICT: strict_ord = val[0];
      REG_SENIOR: senior = val;
      REG_POSTED: posted_col = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_mode(logic op, logic ap, logic so, logic [15:0] sl, logic pc);
    // drain, then let the block settle before touching registers
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    write_reg(REG_OPEN, {15'd0, op});
    write_reg(REG_AUTOP, {15'd0, ap});
    write_reg(REG_STRICT, {15'd0, so});
    write_reg(REG_SENIOR, sl);
    write_reg(REG_POSTED, {15'd0, pc});
    cfg.valid <= 1'b0;
  endtask

  int burst_left = 0;

  // one item, sent at a falling edge; burst/gap idling on the sender
  task automatic send(req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    pending_rsp.push_back(bank_cmd_result(r));
    @(negedge clk);
  endtask

  function automatic req_t rand_req(logic [31:0] tick);
    req_t r;
    r = '0;
    r.command = ($urandom_range(0, 2) == 0);
    r.channel = $urandom_range(0, 1);
    r.rank = $urandom_range(0, 3);
    // a few banks so queues fill and bypasses hit
    r.bank = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
    r.row = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 3));
    r.column = 10'($urandom);
    r.kind = ($urandom_range(0, 9) == 0) ? K_RSV : 2'($urandom_range(0, 2));
    r.burst_length = 4'($urandom);
    r.arrive_tick = $urandom;
    r.now = ($urandom_range(0, 7) == 0) ? $urandom : tick;
    r.tag = 8'($urandom);
    return r;
  endfunction

  typedef struct {
    req_t r;
    logic chk;
    logic [2:0] st;
  } dir_row_t;

  initial begin
    dir_row_t dir [$];
    req_t r;
    logic [31:0] tick;
    req.valid = 1'b0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    rsp.ready = 1'b0;
    open_pg = 1'b0;
    autop = 1'b1;
    strict_ord = 1'b0;
    senior = 16'd1000;
    posted_col = 1'b0;
    for (int q = 0; q < NQ; q++) begin
      occ[q] = 0;
      head[q] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty pop, all kinds, extremes, fill to no room, then pops to drain
    r = '0; r.command = 1'b1; dir.push_back('{r, 1'b1, ST_EMPTY});
    r = '0; r.kind = K_RSV; dir.push_back('{r, 1'b1, ST_UNSUP});
    r = '1; r.command = 1'b0; r.kind = K_RD; dir.push_back('{r, 1'b0, ST_OK});
    r.kind = K_WR; dir.push_back('{r, 1'b0, ST_OK});
    r.kind = K_REF; dir.push_back('{r, 1'b0, ST_OK});
    r.kind = K_RD; dir.push_back('{r, 1'b0, ST_OK});
    r.kind = K_RD; dir.push_back('{r, 1'b1, ST_FULL});
    r.kind = K_RSV; dir.push_back('{r, 1'b1, ST_UNSUP});
    for (int i = 0; i < 9; i++) begin
      r.command = 1'b1; dir.push_back('{r, 1'b0, ST_OK});
    end
    foreach (dir[i]) begin
      send(dir[i].r);
      if (dir[i].chk && pending_rsp[$].status !== dir[i].st)
        report("directed status", pending_rsp[$].status, dir[i].st);
    end

    // settings, extremes first, then random ones
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_mode(1'b0, 1'b0, 1'b0, 16'd0, 1'b1);
        1: set_mode(1'b1, 1'b1, 1'b0, 16'hffff, 1'b0);
        2: set_mode(1'b1, 1'b0, 1'b1, 16'd1000, 1'b1);
        3: set_mode(1'b1, 1'b1, 1'b0, 16'd0, 1'b1);
        default: set_mode(1'($urandom), 1'($urandom), 1'($urandom),
                          16'($urandom_range(0, 40)), 1'($urandom));
      endcase
      tick = $urandom;
      for (int i = 0; i < 90; i++) begin
        tick = tick + $urandom_range(0, 30);
        send(rand_req(tick));
      end
    end

    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
